// ===== src/assert_macros.svh =====
// assertion macros shared by the walker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/fltw_pkg.sv =====
// types, constants and helpers of the four-level page table walker
package fltw_pkg;

   // table memory depth, a power of two
   localparam int MEM_WORDS = 4096;
   localparam int ADDR_W    = $clog2(MEM_WORDS);
   localparam int ENTRY_W   = 64;
   localparam int PA_W      = 52;
   localparam int VA_W      = 48;
   localparam int IDX_W     = 9;
   localparam int WIDX_W    = 12;

   localparam int PRESENT_POS = 0;
   localparam int LARGE_BIT   = 7;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_XLATE = 1'b1;

   localparam logic [1:0] PAGE_4K = 2'd0;
   localparam logic [1:0] PAGE_2M = 2'd1;
   localparam logic [1:0] PAGE_1G = 2'd2;

   typedef enum logic [2:0] {
      WALK_IDLE,
      WALK_L4,
      WALK_L3,
      WALK_L2,
      WALK_L1
   } walk_state_type;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [ENTRY_W-1:0]  wr_data;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic              valid;
      logic              mapped;
      logic [PA_W-1:0]   physical_address;
      logic [1:0]        page_size;
   } rsp_type;

   // memory word of table entry idx in the table at base (low 12 bits of base dropped)
   function automatic logic [ADDR_W-1:0] table_word(input logic [PA_W-1:0] base,
                                                     input logic [IDX_W-1:0] idx);
      logic [PA_W-12+IDX_W-1:0] word;
      word = {base[PA_W-1:12], idx};
      return word[ADDR_W-1:0];
   endfunction

   // write index folded onto the memory depth
   function automatic logic [ADDR_W-1:0] write_word(input logic [WIDX_W-1:0] widx);
      logic [ADDR_W+WIDX_W-1:0] ext;
      ext = {{ADDR_W{1'b0}}, widx};
      return ext[ADDR_W-1:0];
   endfunction

endpackage

// ===== src/fltw_ram.sv =====
// generic single-write single-read ram with registered read
module fltw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fltw_walk.sv =====
// walk sequencer: issues table writes, issues table reads level by level and forms the result
module fltw_walk (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_kind,
   input  logic [fltw_pkg::WIDX_W-1:0]    req_word_index,
   input  logic [fltw_pkg::ENTRY_W-1:0]   req_word_data,
   input  logic [fltw_pkg::VA_W-1:0]      req_virtual_address,
   input  logic [fltw_pkg::PA_W-1:0]      table_root,
   output fltw_pkg::mem_req_type          mem_req,
   input  logic [fltw_pkg::ENTRY_W-1:0]   mem_rd_data,
   output fltw_pkg::rsp_type              rsp
);

   fltw_pkg::walk_state_type state_ff, state_in;
   logic [fltw_pkg::VA_W-1:0] va_ff, va_in;
   fltw_pkg::rsp_type         rsp_ff, rsp_in;

   logic                      accept;
   logic                      present;
   logic                      big_page;
   logic [fltw_pkg::PA_W-1:0] entry_base;

   assign busy       = (state_ff != fltw_pkg::WALK_IDLE);
   assign accept     = start && !busy;
   assign present    = mem_rd_data[fltw_pkg::PRESENT_POS];
   assign big_page   = mem_rd_data[fltw_pkg::LARGE_BIT];
   assign entry_base = mem_rd_data[fltw_pkg::PA_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fltw_pkg::WALK_IDLE: begin
            if (accept && req_kind == fltw_pkg::KIND_XLATE) begin
               state_in = fltw_pkg::WALK_L4;
            end
         end
         fltw_pkg::WALK_L4: begin
            state_in = present ? fltw_pkg::WALK_L3 : fltw_pkg::WALK_IDLE;
         end
         fltw_pkg::WALK_L3: begin
            state_in = (present && !big_page) ? fltw_pkg::WALK_L2 : fltw_pkg::WALK_IDLE;
         end
         fltw_pkg::WALK_L2: begin
            state_in = (present && !big_page) ? fltw_pkg::WALK_L1 : fltw_pkg::WALK_IDLE;
         end
         fltw_pkg::WALK_L1: begin
            state_in = fltw_pkg::WALK_IDLE;
         end
         default: begin
            state_in = fltw_pkg::WALK_IDLE;
         end
      endcase
   end

   // memory requests and result
   always_comb begin
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = fltw_pkg::write_word(req_word_index);
      mem_req.wr_data = req_word_data;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = fltw_pkg::table_word(entry_base, va_ff[38:30]);
      va_in           = va_ff;
      rsp_in          = '0;
      unique case (state_ff)
         fltw_pkg::WALK_IDLE: begin
            if (accept) begin
               if (req_kind == fltw_pkg::KIND_WRITE) begin
                  mem_req.wr_en = 1'b1;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = fltw_pkg::table_word(table_root,
                                                         req_virtual_address[47:39]);
                  va_in           = req_virtual_address;
               end
            end
         end
         fltw_pkg::WALK_L4: begin
            if (present) begin
               mem_req.rd_en = 1'b1;
            end else begin
               rsp_in.valid = 1'b1;
            end
         end
         fltw_pkg::WALK_L3: begin
            if (!present) begin
               rsp_in.valid = 1'b1;
            end else if (big_page) begin
               // 1 GiB base keeps entry bits 51:31, bit 30 stays clear
               rsp_in.valid            = 1'b1;
               rsp_in.mapped           = 1'b1;
               rsp_in.physical_address = {mem_rd_data[51:31], 1'b0, va_ff[29:0]};
               rsp_in.page_size        = fltw_pkg::PAGE_1G;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = fltw_pkg::table_word(entry_base, va_ff[29:21]);
            end
         end
         fltw_pkg::WALK_L2: begin
            if (!present) begin
               rsp_in.valid = 1'b1;
            end else if (big_page) begin
               rsp_in.valid            = 1'b1;
               rsp_in.mapped           = 1'b1;
               rsp_in.physical_address = {mem_rd_data[51:21], va_ff[20:0]};
               rsp_in.page_size        = fltw_pkg::PAGE_2M;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = fltw_pkg::table_word(entry_base, va_ff[20:12]);
            end
         end
         fltw_pkg::WALK_L1: begin
            rsp_in.valid = 1'b1;
            if (present) begin
               rsp_in.mapped           = 1'b1;
               rsp_in.physical_address = {mem_rd_data[51:12], va_ff[11:0]};
               rsp_in.page_size        = fltw_pkg::PAGE_4K;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fltw_pkg::WALK_IDLE;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff <= va_in;
   end

   assign rsp = rsp_ff;

endmodule

// ===== src/four_level_page_table_walker.sv =====
// top level of the four-level page table walker: root register, table memory, walk sequencer
`include "assert_macros.svh"

// Translates 48-bit virtual addresses through four levels of page tables held in an
// internal table memory of fltw_pkg::MEM_WORDS 64-bit words (power of two). A request
// with req_kind 0 writes one table word; busy stays low and no response follows. A
// request with req_kind 1 walks the tables, each read using the entry read before it from
// the single table memory; busy is high during the walk (a miss or large page ends it
// early) and rsp_valid pulses for exactly one cycle in the first cycle with busy low
// again; a new request may be started in that same cycle. The receiver cannot stall: a
// response must be taken when rsp_valid is high. Table words read before they were ever
// written give undefined results. The root register is written through the csr port,
// which is always ready; the user must write it only while idle, the block does not check.
module four_level_page_table_walker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_kind,
   input  logic [fltw_pkg::WIDX_W-1:0]    req_word_index,
   input  logic [fltw_pkg::ENTRY_W-1:0]   req_word_data,
   input  logic [fltw_pkg::VA_W-1:0]      req_virtual_address,
   output logic                           rsp_valid,
   output logic                           rsp_mapped,
   output logic [fltw_pkg::PA_W-1:0]      rsp_physical_address,
   output logic [1:0]                     rsp_page_size,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fltw_pkg::PA_W-1:0]      csr_table_root
);

   logic [fltw_pkg::PA_W-1:0]    table_root_ff, table_root_in;
   fltw_pkg::mem_req_type        mem_req;
   logic [fltw_pkg::ENTRY_W-1:0] mem_rd_data;
   fltw_pkg::rsp_type            rsp;

   assign csr_ready     = 1'b1;
   assign table_root_in = (csr_valid && csr_ready) ? csr_table_root : table_root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_root_ff <= '0;
      end else begin
         table_root_ff <= table_root_in;
      end
   end

   fltw_walk u_walk (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_word_index      (req_word_index),
      .req_word_data       (req_word_data),
      .req_virtual_address (req_virtual_address),
      .table_root          (table_root_ff),
      .mem_req             (mem_req),
      .mem_rd_data         (mem_rd_data),
      .rsp                 (rsp)
   );

   fltw_ram #(
      .WIDTH (fltw_pkg::ENTRY_W),
      .DEPTH (fltw_pkg::MEM_WORDS)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid            = rsp.valid;
   assign rsp_mapped           = rsp.mapped;
   assign rsp_physical_address = rsp.physical_address;
   assign rsp_page_size        = rsp.page_size;

   `ASSERT_NEXT(a_xlate_goes_busy, clock, reset, start && !busy && req_kind == fltw_pkg::KIND_XLATE, busy)
   `ASSERT_NEXT(a_write_stays_free, clock, reset, start && !busy && req_kind == fltw_pkg::KIND_WRITE, !busy && !rsp_valid)
   `ASSERT_IMPLY(a_rsp_ends_walk, clock, reset, rsp_valid, $past(busy))
   `ASSERT_IMPLY(a_miss_is_zero, clock, reset, rsp_valid && !rsp_mapped, rsp_physical_address == '0 && rsp_page_size == fltw_pkg::PAGE_4K)

endmodule

// ===== test/translation_checker.sv =====
`timescale 1ns / 100ps
// page table walker checker: mirrors table writes and the root, predicts and compares translations
module translation_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           req_kind,
   input  logic [fltw_pkg::WIDX_W-1:0]    req_word_index,
   input  logic [fltw_pkg::ENTRY_W-1:0]   req_word_data,
   input  logic [fltw_pkg::VA_W-1:0]      req_virtual_address,
   input  logic                           rsp_valid,
   input  logic                           rsp_mapped,
   input  logic [fltw_pkg::PA_W-1:0]      rsp_physical_address,
   input  logic [1:0]                     rsp_page_size,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [fltw_pkg::PA_W-1:0]      csr_table_root,
   output int                             outstanding,
   output int                             mismatches
);

   localparam int LVL_PML4 = 0;
   localparam int LVL_PDPT = 1;
   localparam int LVL_PD   = 2;
   localparam int LVL_PT   = 3;

   typedef struct packed {
      logic [fltw_pkg::VA_W-1:0] va;
      logic                      mapped;
      logic [fltw_pkg::PA_W-1:0] pa;
      logic [1:0]                size;
   } translation_type;

   logic [fltw_pkg::ENTRY_W-1:0] table_words [fltw_pkg::MEM_WORDS];
   logic [fltw_pkg::PA_W-1:0]    root;
   translation_type              pending_translations [$];
   int                           fail_count = 0;

   // memory word holding entry idx of the table at base
   function automatic int entry_slot(input logic [fltw_pkg::PA_W-1:0] base,
                                     input logic [fltw_pkg::IDX_W-1:0] idx);
      logic [63:0] addr;
      addr = {12'b0, base[fltw_pkg::PA_W-1:12], 12'b0} + {52'b0, idx, 3'b000};
      return int'((addr >> 3) % fltw_pkg::MEM_WORDS);
   endfunction

   function automatic translation_type predict_translation(
         input logic [fltw_pkg::VA_W-1:0] va);
      translation_type              r;
      logic [fltw_pkg::ENTRY_W-1:0] e;
      logic [fltw_pkg::PA_W-1:0]    base;
      int                           lvl;
      r = '0;
      r.va = va;
      base = root;
      for (lvl = LVL_PML4; lvl <= LVL_PT; lvl++) begin
         e = table_words[entry_slot(base, va[39 - 9 * lvl +: fltw_pkg::IDX_W])];
         if (!e[fltw_pkg::PRESENT_POS])
            return r;
         if (lvl == LVL_PDPT && e[fltw_pkg::LARGE_BIT]) begin
            // 1 GiB base keeps entry bits 51:31, bit 30 stays clear
            r.mapped = 1'b1;
            r.pa = {e[fltw_pkg::PA_W-1:31], 1'b0, va[29:0]};
            r.size = fltw_pkg::PAGE_1G;
            return r;
         end
         if (lvl == LVL_PD && e[fltw_pkg::LARGE_BIT]) begin
            r.mapped = 1'b1;
            r.pa = {e[fltw_pkg::PA_W-1:21], va[20:0]};
            r.size = fltw_pkg::PAGE_2M;
            return r;
         end
         if (lvl == LVL_PT) begin
            r.mapped = 1'b1;
            r.pa = {e[fltw_pkg::PA_W-1:12], va[11:0]};
            r.size = fltw_pkg::PAGE_4K;
            return r;
         end
         base = e[fltw_pkg::PA_W-1:0];
      end
      return r;
   endfunction

   function automatic void check_field(input string name,
                                       input logic [fltw_pkg::VA_W-1:0] va,
                                       input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: va %h %s expected %h actual %h", $time, va, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      translation_type want;
      if (reset) begin
         root = '0;
         pending_translations.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_translations.size() == 0) begin
               $display("%0t: response beat with nothing outstanding: mapped %0d pa %h size %0d",
                        $time, rsp_mapped, rsp_physical_address, rsp_page_size);
               fail_count++;
            end else begin
               want = pending_translations.pop_front();
               check_field("mapped", want.va, 64'(want.mapped), 64'(rsp_mapped));
               check_field("physical_address", want.va, 64'(want.pa),
                           64'(rsp_physical_address));
               check_field("page_size", want.va, 64'(want.size), 64'(rsp_page_size));
            end
         end
         // a walk started on this edge still sees the old root
         if (start && !busy) begin
            if (req_kind == fltw_pkg::KIND_WRITE)
               table_words[req_word_index % fltw_pkg::MEM_WORDS] = req_word_data;
            else
               pending_translations.push_back(predict_translation(req_virtual_address));
         end
         if (csr_valid && csr_ready)
            root = csr_table_root;
      end
      outstanding <= pending_translations.size();
      mismatches <= fail_count;
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// page table walker testbench top: clock, reset, table and translate stimulus, verdict
module testbench;

   localparam int CYCLE_LIMIT = 400000;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic                           req_kind;
   logic [fltw_pkg::WIDX_W-1:0]    req_word_index;
   logic [fltw_pkg::ENTRY_W-1:0]   req_word_data;
   logic [fltw_pkg::VA_W-1:0]      req_virtual_address;
   logic                           rsp_valid;
   logic                           rsp_mapped;
   logic [fltw_pkg::PA_W-1:0]      rsp_physical_address;
   logic [1:0]                     rsp_page_size;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [fltw_pkg::PA_W-1:0]      csr_table_root;

   int outstanding;
   int mismatches;
   int cycle_count = 0;

   // stimulus-side copy of the table memory, used only to keep walks on written words
   logic [fltw_pkg::ENTRY_W-1:0] shadow_words [fltw_pkg::MEM_WORDS];
   bit                           word_written [fltw_pkg::MEM_WORDS];
   logic [fltw_pkg::PA_W-1:0]    root_now;
   logic [fltw_pkg::VA_W-1:0]    last_va;
   int                           idle_pct;
   int                           items_sent;

   four_level_page_table_walker dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_kind             (req_kind),
      .req_word_index       (req_word_index),
      .req_word_data        (req_word_data),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_mapped           (rsp_mapped),
      .rsp_physical_address (rsp_physical_address),
      .rsp_page_size        (rsp_page_size),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_table_root       (csr_table_root)
   );

   translation_checker translation_check (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_kind             (req_kind),
      .req_word_index       (req_word_index),
      .req_word_data        (req_word_data),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_mapped           (rsp_mapped),
      .rsp_physical_address (rsp_physical_address),
      .rsp_page_size        (rsp_page_size),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_table_root       (csr_table_root),
      .outstanding          (outstanding),
      .mismatches           (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("four_level_page_table_walker regression: fail");
         $finish;
      end
   end

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic int table_slot(input logic [fltw_pkg::PA_W-1:0] base,
                                     input logic [fltw_pkg::IDX_W-1:0] idx);
      logic [63:0] a;
      a = {12'b0, base};
      return int'((((a >> 12) << fltw_pkg::IDX_W) | {55'b0, idx}) % fltw_pkg::MEM_WORDS);
   endfunction

   // mostly present entries; large pages only matter at the directory-pointer and directory levels
   function automatic logic [fltw_pkg::ENTRY_W-1:0] random_entry(input int lvl);
      logic [fltw_pkg::ENTRY_W-1:0] e;
      e = random_word();
      e[fltw_pkg::PRESENT_POS] = ($urandom_range(99) < 88);
      if (lvl == 1 || lvl == 2)
         e[fltw_pkg::LARGE_BIT] = ($urandom_range(99) < 30);
      return e;
   endfunction

   // start stays high across back-to-back beats
   task automatic issue_item(input logic kind, input logic [fltw_pkg::WIDX_W-1:0] widx,
                             input logic [fltw_pkg::ENTRY_W-1:0] data,
                             input logic [fltw_pkg::VA_W-1:0] va);
      req_kind <= kind;
      req_word_index <= widx;
      req_word_data <= data;
      req_virtual_address <= va;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic put_table_word(input int slot, input logic [fltw_pkg::ENTRY_W-1:0] data);
      logic [63:0] noise;
      noise = random_word();
      shadow_words[slot] = data;
      word_written[slot] = 1'b1;
      issue_item(fltw_pkg::KIND_WRITE, slot[fltw_pkg::WIDX_W-1:0], data,
                 noise[fltw_pkg::VA_W-1:0]);
   endtask

   // fill every word the walk of va will read that was never written
   task automatic prepare_walk(input logic [fltw_pkg::VA_W-1:0] va);
      logic [fltw_pkg::PA_W-1:0]    base;
      logic [fltw_pkg::ENTRY_W-1:0] e;
      int                           slot;
      int                           lvl;
      bit                           done;
      base = root_now;
      done = 1'b0;
      for (lvl = 0; lvl < 4 && !done; lvl++) begin
         slot = table_slot(base, va[39 - 9 * lvl +: fltw_pkg::IDX_W]);
         if (!word_written[slot])
            put_table_word(slot, random_entry(lvl));
         e = shadow_words[slot];
         done = !e[fltw_pkg::PRESENT_POS] || (e[fltw_pkg::LARGE_BIT] && (lvl == 1 || lvl == 2));
         base = e[fltw_pkg::PA_W-1:0];
      end
   endtask

   task automatic translate(input logic [fltw_pkg::VA_W-1:0] va);
      logic [63:0] noise;
      noise = random_word();
      prepare_walk(va);
      issue_item(fltw_pkg::KIND_XLATE, noise[fltw_pkg::WIDX_W-1:0], random_word(), va);
      last_va = va;
   endtask

   task automatic settle();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_root(input logic [fltw_pkg::PA_W-1:0] r);
      csr_table_root <= r;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      root_now = r;
   endtask

   // root 0: tables 0..3 chained at index 0, side branches for misses and large pages
   task automatic directed_walks();
      put_table_word(0, 64'hFFF0_0000_0000_1081);
      put_table_word(512, 64'h0000_0000_0000_2001);
      put_table_word(1024, 64'h0000_0000_0000_3001);
      put_table_word(1536, 64'hFFFF_FFFF_FFFF_F081);
      put_table_word(1537, 64'h0);
      put_table_word(1025, 64'hFFFF_FFFF_FFFF_FFFF);
      put_table_word(1026, 64'h0000_0000_0000_0002);
      put_table_word(513, 64'h8000_0000_C000_0081);
      put_table_word(514, 64'h0000_0000_0000_0080);
      put_table_word(1, 64'hFFFF_FFFF_FFFF_FFFE);
      put_table_word(511, 64'h0000_0000_0000_4001);
      put_table_word(2559, 64'h0FFF_FFFF_FFFF_FFFF);
      put_table_word(fltw_pkg::MEM_WORDS - 1, 64'hFFFF_FFFF_FFFF_FFFF);
      translate(48'h0);
      translate(48'h0000_0000_0ABC);
      translate(48'h0000_0000_1000);
      translate(48'h0000_003F_FFFF);
      translate(48'h0000_0040_0000);
      translate(48'h0000_5234_5678);
      translate(48'h0000_8000_0000);
      translate(48'h0080_0000_0000);
      translate(48'hFFFF_FFFF_FFFF);
   endtask

   task automatic random_phase(input logic [fltw_pkg::PA_W-1:0] root, input int pct,
                               input int count);
      logic [63:0]               w;
      logic [fltw_pkg::VA_W-1:0] va;
      int                        target;
      int                        pick;
      settle();
      set_root(root);
      idle_pct = pct;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         w = random_word();
         if (pick < 15) begin
            put_table_word($urandom_range(fltw_pkg::MEM_WORDS - 1), random_word());
         end else begin
            // reuse upper levels of the last walk now and then
            if (pick < 35)
               va = {last_va[fltw_pkg::VA_W-1:21], w[20:0]};
            else if (pick < 55)
               va = {last_va[fltw_pkg::VA_W-1:30], w[29:0]};
            else
               va = w[fltw_pkg::VA_W-1:0];
            translate(va);
         end
      end
   endtask

   initial begin
      logic [63:0] r;
      reset <= 1'b1;
      start <= 1'b0;
      req_kind <= fltw_pkg::KIND_WRITE;
      req_word_index <= '0;
      req_word_data <= '0;
      req_virtual_address <= '0;
      csr_valid <= 1'b0;
      csr_table_root <= '0;
      idle_pct = 11;
      items_sent = 0;
      last_va = '0;
      root_now = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_root('0);
      directed_walks();
      r = random_word();
      random_phase(r[fltw_pkg::PA_W-1:0], 11, 460);
      random_phase('1, 53, 460);
      r = random_word();
      random_phase(r[fltw_pkg::PA_W-1:0], 0, 440);
      settle();
      if (mismatches == 0 && outstanding == 0)
         $display("four_level_page_table_walker regression: pass");
      else
         $display("four_level_page_table_walker regression: fail");
      $finish;
   end

endmodule
